// ===== rtl/core/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the sorted list rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/core/spcl_pkg.sv =====
// spcl_pkg: types and constants of the sorted priority cost list
// no dependencies
package spcl_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int KEY_WIDTH_DEF = 16;
   localparam int POS_WIDTH     = 5;
   localparam int KIND_WIDTH    = 2;
   localparam int STATUS_WIDTH  = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_INSERT = 2'd0,
      KIND_SEARCH = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_LIST   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/sorted_priority_cost_list.sv =====
// sorted_priority_cost_list: top level of the sorted (priority, cost) table
// depends on spcl_pkg, spcl_chain and assert_macros.svh
//
// items enter on start/req_* and are taken at a clock edge with start high
// and busy low. req_kind selects insert, search, remove or list.
// results leave on rsp_* for exactly one cycle, marked by rsp_strobe; the
// receiver cannot stall, so every result is taken in the cycle it is shown.
// insert, search and remove: one result, shown the cycle after the item is
// taken; busy stays low, so a new item can be taken every cycle.
// list: busy rises and stays high while the N entries of the table are read;
// one entry is shown per cycle, the first one once busy has risen, with
// rsp_last on the final one; an empty table gives a single empty result
// the next cycle. the list rate is set by the single read port of the row.
// the table is a row of DEPTH cells that compare and shift in parallel.
// reset empties the table and drops busy and rsp_strobe.
`include "assert_macros.svh"

module sorted_priority_cost_list #(
   parameter int DEPTH     = spcl_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = spcl_pkg::KEY_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [spcl_pkg::KIND_WIDTH-1:0]     req_kind,
   input  logic signed [KEY_WIDTH-1:0]         req_priority_req,
   input  logic signed [KEY_WIDTH-1:0]         req_cost,
   output logic                                rsp_strobe,
   output logic [spcl_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic [spcl_pkg::POS_WIDTH-1:0]      rsp_position,
   output logic signed [KEY_WIDTH-1:0]         rsp_entry_priority,
   output logic signed [KEY_WIDTH-1:0]         rsp_entry_cost,
   output logic                                rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                           busy_ff, busy_in;
   logic [IDX_W-1:0]               list_idx_ff, list_idx_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           strobe_ff, strobe_in;
   spcl_pkg::status_type           status_ff, status_in;
   logic [spcl_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic signed [KEY_WIDTH-1:0]    eprio_ff, eprio_in;
   logic signed [KEY_WIDTH-1:0]    ecost_ff, ecost_in;
   logic                           last_ff, last_in;

   spcl_pkg::cell_ctrl_type        ctrl;
   logic                           full, found, list_done;
   logic [IDX_W-1:0]               hit_idx, ins_idx;
   logic signed [KEY_WIDTH-1:0]    hit_prio, hit_cost, list_prio, list_cost;

   spcl_chain #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .new_prio  (req_priority_req),
      .new_cost  (req_cost),
      .list_idx  (list_idx_ff),
      .full      (full),
      .found     (found),
      .hit_idx   (hit_idx),
      .hit_prio  (hit_prio),
      .hit_cost  (hit_cost),
      .ins_idx   (ins_idx),
      .list_prio (list_prio),
      .list_cost (list_cost)
   );

   assign list_done = (CNT_W'(list_idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      busy_in     = busy_ff;
      list_idx_in = list_idx_ff;
      count_in    = count_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      pos_in      = pos_ff;
      eprio_in    = eprio_ff;
      ecost_in    = ecost_ff;
      last_in     = last_ff;
      ctrl        = '0;
      if (busy_ff) begin
         strobe_in = 1'b1;
         status_in = spcl_pkg::STATUS_OK;
         pos_in    = spcl_pkg::POS_WIDTH'(list_idx_ff);
         eprio_in  = list_prio;
         ecost_in  = list_cost;
         last_in   = list_done;
         if (list_done) begin
            busy_in = 1'b0;
         end else begin
            list_idx_in = list_idx_ff + IDX_W'(1);
         end
      end else if (start) begin
         unique case (spcl_pkg::kind_type'(req_kind))
            spcl_pkg::KIND_INSERT: begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
               eprio_in  = req_priority_req;
               ecost_in  = req_cost;
               if (full) begin
                  status_in = spcl_pkg::STATUS_FULL;
                  pos_in    = '0;
               end else begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  status_in   = spcl_pkg::STATUS_OK;
                  pos_in      = spcl_pkg::POS_WIDTH'(ins_idx);
               end
            end
            spcl_pkg::KIND_SEARCH, spcl_pkg::KIND_REMOVE: begin
               strobe_in   = 1'b1;
               last_in     = 1'b1;
               ctrl.remove = (spcl_pkg::kind_type'(req_kind) == spcl_pkg::KIND_REMOVE);
               if (found) begin
                  status_in = spcl_pkg::STATUS_OK;
                  pos_in    = spcl_pkg::POS_WIDTH'(hit_idx);
                  eprio_in  = hit_prio;
                  ecost_in  = hit_cost;
                  if (ctrl.remove) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end else begin
                  status_in = spcl_pkg::STATUS_NOT_FOUND;
                  pos_in    = '0;
                  eprio_in  = '0;
                  ecost_in  = '0;
               end
            end
            spcl_pkg::KIND_LIST: begin
               if (count_ff == '0) begin
                  strobe_in = 1'b1;
                  last_in   = 1'b1;
                  status_in = spcl_pkg::STATUS_EMPTY;
                  pos_in    = '0;
                  eprio_in  = '0;
                  ecost_in  = '0;
               end else begin
                  busy_in     = 1'b1;
                  list_idx_in = '0;
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      eprio_ff    <= eprio_in;
      ecost_ff    <= ecost_in;
      last_ff     <= last_in;
      list_idx_ff <= list_idx_in;
      if (reset) begin
         busy_ff   <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy               = busy_ff;
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_position       = pos_ff;
   assign rsp_entry_priority = eprio_ff;
   assign rsp_entry_cost     = ecost_ff;
   assign rsp_last           = last_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(DEPTH))
   `ASSERT_PROP(a_busy_nonempty, clock, reset, busy_ff |-> (count_ff != '0))
   `ASSERT_PROP(a_full_count, clock, reset, full == (count_ff == CNT_W'(DEPTH)))

endmodule

// ===== rtl/core/spcl_cell.sv =====
// spcl_cell: one entry of the sorted chain with its compare and shift logic
// depends on spcl_pkg
module spcl_cell #(
   parameter int KEY_WIDTH = spcl_pkg::KEY_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spcl_pkg::cell_ctrl_type     ctrl,
   input  logic signed [KEY_WIDTH-1:0] new_prio,
   input  logic signed [KEY_WIDTH-1:0] new_cost,
   input  logic signed [KEY_WIDTH-1:0] left_prio,
   input  logic signed [KEY_WIDTH-1:0] left_cost,
   input  logic                        left_valid,
   input  logic                        left_less,
   input  logic signed [KEY_WIDTH-1:0] right_prio,
   input  logic signed [KEY_WIDTH-1:0] right_cost,
   input  logic                        right_valid,
   output logic signed [KEY_WIDTH-1:0] prio,
   output logic signed [KEY_WIDTH-1:0] cost,
   output logic                        valid,
   output logic                        less,
   output logic                        match,
   output logic                        geq
);

   logic signed [KEY_WIDTH-1:0] prio_ff, prio_in;
   logic signed [KEY_WIDTH-1:0] cost_ff, cost_in;
   logic                        valid_ff, valid_in;

   assign prio  = prio_ff;
   assign cost  = cost_ff;
   assign valid = valid_ff;
   assign less  = valid_ff && ((prio_ff < new_prio) ||
                               ((prio_ff == new_prio) && (cost_ff < new_cost)));
   assign match = valid_ff && (prio_ff == new_prio);
   assign geq   = valid_ff && (prio_ff >= new_prio);

   always_comb begin
      prio_in  = prio_ff;
      cost_in  = cost_ff;
      valid_in = valid_ff;
      if (ctrl.insert && !less) begin
         if (left_less) begin
            prio_in  = new_prio;
            cost_in  = new_cost;
            valid_in = 1'b1;
         end else begin
            prio_in  = left_prio;
            cost_in  = left_cost;
            valid_in = left_valid;
         end
      end else if (ctrl.remove && geq) begin
         prio_in  = right_prio;
         cost_in  = right_cost;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      cost_ff <= cost_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/core/spcl_chain.sv =====
// spcl_chain: row of spcl_cell entries with neighbor wiring and result selection
// depends on spcl_pkg, spcl_cell and assert_macros.svh
`include "assert_macros.svh"

module spcl_chain #(
   parameter int DEPTH     = spcl_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = spcl_pkg::KEY_WIDTH_DEF,
   localparam int IDX_W    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spcl_pkg::cell_ctrl_type     ctrl,
   input  logic signed [KEY_WIDTH-1:0] new_prio,
   input  logic signed [KEY_WIDTH-1:0] new_cost,
   input  logic [IDX_W-1:0]            list_idx,
   output logic                        full,
   output logic                        found,
   output logic [IDX_W-1:0]            hit_idx,
   output logic signed [KEY_WIDTH-1:0] hit_prio,
   output logic signed [KEY_WIDTH-1:0] hit_cost,
   output logic [IDX_W-1:0]            ins_idx,
   output logic signed [KEY_WIDTH-1:0] list_prio,
   output logic signed [KEY_WIDTH-1:0] list_cost
);

   logic signed [KEY_WIDTH-1:0] prio [DEPTH];
   logic signed [KEY_WIDTH-1:0] cost [DEPTH];
   logic signed [KEY_WIDTH-1:0] left_prio [DEPTH];
   logic signed [KEY_WIDTH-1:0] left_cost [DEPTH];
   logic signed [KEY_WIDTH-1:0] right_prio [DEPTH];
   logic signed [KEY_WIDTH-1:0] right_cost [DEPTH];
   logic [DEPTH-1:0]            valid_vec, less_vec, match_vec, geq_vec;
   logic [DEPTH-1:0]            left_valid, left_less, right_valid;
   logic [DEPTH-1:0]            first, bnd;
   spcl_pkg::cell_ctrl_type     cell_ctrl;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_prio[i]  = '0;
         assign left_cost[i]  = '0;
         assign left_valid[i] = 1'b0;
         assign left_less[i]  = 1'b1;
         assign first[i]      = match_vec[i];
         assign bnd[i]        = !less_vec[i];
      end else begin : g_body
         assign left_prio[i]  = prio[i-1];
         assign left_cost[i]  = cost[i-1];
         assign left_valid[i] = valid_vec[i-1];
         assign left_less[i]  = less_vec[i-1];
         assign first[i]      = match_vec[i] && !match_vec[i-1];
         assign bnd[i]        = !less_vec[i] && less_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_prio[i]  = '0;
         assign right_cost[i]  = '0;
         assign right_valid[i] = 1'b0;
      end else begin : g_inner
         assign right_prio[i]  = prio[i+1];
         assign right_cost[i]  = cost[i+1];
         assign right_valid[i] = valid_vec[i+1];
      end

      spcl_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .new_prio    (new_prio),
         .new_cost    (new_cost),
         .left_prio   (left_prio[i]),
         .left_cost   (left_cost[i]),
         .left_valid  (left_valid[i]),
         .left_less   (left_less[i]),
         .right_prio  (right_prio[i]),
         .right_cost  (right_cost[i]),
         .right_valid (right_valid[i]),
         .prio        (prio[i]),
         .cost        (cost[i]),
         .valid       (valid_vec[i]),
         .less        (less_vec[i]),
         .match       (match_vec[i]),
         .geq         (geq_vec[i])
      );
   end

   assign full             = valid_vec[DEPTH-1];
   assign found            = |first;
   assign cell_ctrl.insert = ctrl.insert;
   assign cell_ctrl.remove = ctrl.remove && found;

   always_comb begin
      hit_idx   = '0;
      hit_prio  = '0;
      hit_cost  = '0;
      ins_idx   = '0;
      list_prio = '0;
      list_cost = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_prio = hit_prio | prio[i];
            hit_cost = hit_cost | cost[i];
         end
         if (bnd[i]) begin
            ins_idx = ins_idx | IDX_W'(i);
         end
         if (list_idx == IDX_W'(i)) begin
            list_prio = list_prio | prio[i];
            list_cost = list_cost | cost[i];
         end
      end
   end

   `ASSERT_PROP(a_first_onehot, clock, reset, $onehot0(first))
   `ASSERT_NEVER(a_valid_prefix, clock, reset, ((valid_vec + 1'b1) & valid_vec) != '0)
   `ASSERT_PROP(a_bnd_onehot, clock, reset, !full |-> $onehot(bnd))

endmodule

// ===== bench/spcl_checker.sv =====
// spcl_checker: watches both channels of sorted_priority_cost_list, keeps its own
// sorted table, predicts every result and compares it field by field
// depends on spcl_pkg
module spcl_checker
   import spcl_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [KIND_WIDTH-1:0]       req_kind,
   input  logic signed [KEY_WIDTH-1:0] req_priority_req,
   input  logic signed [KEY_WIDTH-1:0] req_cost,
   input  logic                        rsp_strobe,
   input  logic [STATUS_WIDTH-1:0]     rsp_status,
   input  logic [POS_WIDTH-1:0]        rsp_position,
   input  logic signed [KEY_WIDTH-1:0] rsp_entry_priority,
   input  logic signed [KEY_WIDTH-1:0] rsp_entry_cost,
   input  logic                        rsp_last,
   output int                          fail_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type                  status;
      logic [POS_WIDTH-1:0]        position;
      logic signed [KEY_WIDTH-1:0] prio;
      logic signed [KEY_WIDTH-1:0] cost;
      logic                        last;
   } entry_result_type;

   logic signed [KEY_WIDTH-1:0] slot_prio [DEPTH];
   logic signed [KEY_WIDTH-1:0] slot_cost [DEPTH];
   int                          entry_total;
   entry_result_type            expected_results [$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void add_expected(input status_type st, input int pos,
                                        input logic signed [KEY_WIDTH-1:0] p,
                                        input logic signed [KEY_WIDTH-1:0] c,
                                        input logic last);
      entry_result_type res;
      res.status   = st;
      res.position = POS_WIDTH'(pos);
      res.prio     = p;
      res.cost     = c;
      res.last     = last;
      expected_results.push_back(res);
   endfunction

   task automatic predict_table_op(input kind_type kind,
                                   input logic signed [KEY_WIDTH-1:0] p,
                                   input logic signed [KEY_WIDTH-1:0] c);
      int slot;
      logic signed [KEY_WIDTH-1:0] hit_prio;
      logic signed [KEY_WIDTH-1:0] hit_cost;
      case (kind)
         KIND_INSERT: begin
            if (entry_total >= DEPTH) begin
               add_expected(STATUS_FULL, 0, p, c, 1'b1);
            end else begin
               slot = 0;
               while (slot < entry_total && (slot_prio[slot] < p ||
                      (slot_prio[slot] == p && slot_cost[slot] < c)))
                  slot++;
               for (int j = entry_total; j > slot; j--) begin
                  slot_prio[j] = slot_prio[j-1];
                  slot_cost[j] = slot_cost[j-1];
               end
               slot_prio[slot] = p;
               slot_cost[slot] = c;
               entry_total++;
               add_expected(STATUS_OK, slot, p, c, 1'b1);
            end
         end
         KIND_SEARCH, KIND_REMOVE: begin
            slot = 0;
            while (slot < entry_total && slot_prio[slot] != p)
               slot++;
            if (slot >= entry_total) begin
               add_expected(STATUS_NOT_FOUND, 0, '0, '0, 1'b1);
            end else begin
               hit_prio = slot_prio[slot];
               hit_cost = slot_cost[slot];
               if (kind == KIND_REMOVE) begin
                  for (int j = slot; j + 1 < entry_total; j++) begin
                     slot_prio[j] = slot_prio[j+1];
                     slot_cost[j] = slot_cost[j+1];
                  end
                  entry_total--;
               end
               add_expected(STATUS_OK, slot, hit_prio, hit_cost, 1'b1);
            end
         end
         default: begin
            if (entry_total == 0) begin
               add_expected(STATUS_EMPTY, 0, '0, '0, 1'b1);
            end else begin
               for (int j = 0; j < entry_total; j++)
                  add_expected(STATUS_OK, j, slot_prio[j], slot_cost[j],
                               j + 1 == entry_total);
            end
         end
      endcase
   endtask

   task automatic check_result();
      entry_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result with none expected: status %0d position %0d",
                                   rsp_status, rsp_position));
         return;
      end
      want = expected_results.pop_front();
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
      if (rsp_position !== want.position)
         report_mismatch($sformatf("position %0d, expected %0d", rsp_position,
                                   want.position));
      if (rsp_entry_priority !== want.prio)
         report_mismatch($sformatf("entry_priority %0d, expected %0d",
                                   rsp_entry_priority, want.prio));
      if (rsp_entry_cost !== want.cost)
         report_mismatch($sformatf("entry_cost %0d, expected %0d", rsp_entry_cost,
                                   want.cost));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entry_total   = 0;
         fail_count    = 0;
         pending_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_strobe)
            check_result();
         if (start && !busy)
            predict_table_op(kind_type'(req_kind), req_priority_req, req_cost);
         pending_count = expected_results.size();
      end
   end

endmodule

// ===== bench/tb_sorted_priority_cost_list.sv =====
// tb_sorted_priority_cost_list: drives directed and random items into the sorted
// priority cost list with random gaps and gives the verdict
// depends on spcl_pkg, spcl_checker and the sorted_priority_cost_list rtl
module tb_sorted_priority_cost_list;
   timeunit 1ns;
   timeprecision 1ps;
   import spcl_pkg::*;

   localparam int KW           = KEY_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 93;
   localparam int STALL_LIMIT  = 500;
   localparam int TAIL_CYCLES  = 20;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [KIND_WIDTH-1:0]   req_kind;
   logic signed [KW-1:0]    req_priority_req;
   logic signed [KW-1:0]    req_cost;
   logic                    rsp_strobe;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [POS_WIDTH-1:0]    rsp_position;
   logic signed [KW-1:0]    rsp_entry_priority;
   logic signed [KW-1:0]    rsp_entry_cost;
   logic                    rsp_last;
   int                      fail_count;
   int                      pending_count;
   bit                      burst;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_priority_cost_list u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_priority_req   (req_priority_req),
      .req_cost           (req_cost),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_position       (rsp_position),
      .rsp_entry_priority (rsp_entry_priority),
      .rsp_entry_cost     (rsp_entry_cost),
      .rsp_last           (rsp_last)
   );

   spcl_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_priority_req   (req_priority_req),
      .req_cost           (req_cost),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_position       (rsp_position),
      .rsp_entry_priority (rsp_entry_priority),
      .rsp_entry_cost     (rsp_entry_cost),
      .rsp_last           (rsp_last),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   // called at a rising edge; returns at a rising edge
   task automatic send_item(input kind_type kind, input logic signed [KW-1:0] prio,
                            input logic signed [KW-1:0] cost);
      int gap;
      start            <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= prio;
      req_cost         <= cost;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly a narrow band so that ties, hits and duplicates are common
   function automatic logic signed [KW-1:0] pick_key();
      int v;
      if ($urandom_range(0, 3) != 0)
         v = int'($urandom_range(0, 11)) - 6;
      else
         v = int'($urandom);
      return v[KW-1:0];
   endfunction

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      bit       fill_bias;
      int       roll;
      kind_type kind;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_kind         <= KIND_INSERT;
      req_priority_req <= '0;
      req_cost         <= '0;
      burst = 1'b0;
      fill_bias = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table
      send_item(KIND_LIST, 16'sd0, 16'sd0);
      send_item(KIND_SEARCH, 16'sd5, 16'sd0);
      send_item(KIND_REMOVE, 16'sd5, 16'sd0);
      // extremes and ties
      send_item(KIND_INSERT, 16'sh7fff, 16'sh7fff);
      send_item(KIND_INSERT, 16'sh8000, 16'sh8000);
      send_item(KIND_INSERT, 16'sd0, 16'sd0);
      send_item(KIND_INSERT, 16'sh8000, 16'sh7fff);
      send_item(KIND_INSERT, 16'sh7fff, 16'sh8000);
      send_item(KIND_INSERT, 16'sd0, 16'sd0);
      send_item(KIND_INSERT, 16'sd0, 16'sd5);
      send_item(KIND_INSERT, -16'sd1, -16'sd5);
      send_item(KIND_INSERT, 16'sd0, -16'sd5);
      send_item(KIND_SEARCH, 16'sd0, 16'sd0);
      send_item(KIND_SEARCH, 16'sd1, 16'sd0);
      send_item(KIND_REMOVE, 16'sd0, 16'sd0);
      send_item(KIND_LIST, 16'sd0, 16'sd0);
      // fill up, then reject one
      for (int k = 0; k < 8; k++)
         send_item(KIND_INSERT, 16'(k * 3001 - 12000), 16'((k % 2) ? 16'h5555 : 16'haaaa));
      send_item(KIND_INSERT, 16'sd0, 16'sd1);
      send_item(KIND_LIST, 16'sd0, 16'sd0);
      send_item(KIND_REMOVE, 16'sh7fff, 16'sd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 20 == 0) begin
            fill_bias = !fill_bias;
            burst = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < 8)
            kind = KIND_LIST;
         else if (roll < 22)
            kind = KIND_SEARCH;
         else if ($urandom_range(0, 99) < (fill_bias ? 90 : 10))
            kind = KIND_INSERT;
         else
            kind = KIND_REMOVE;
         send_item(kind, pick_key(), pick_key());
      end
      start <= 1'b0;

      while (pending_count != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== sorted_priority_cost_list.f =====
+incdir+rtl/core
rtl/core/spcl_pkg.sv
rtl/core/spcl_cell.sv
rtl/core/spcl_chain.sv
rtl/core/sorted_priority_cost_list.sv
bench/spcl_checker.sv
bench/tb_sorted_priority_cost_list.sv
